// ===== sv/frc_pkg.sv =====
`default_nettype none
package frc_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [5:0] HDR_LAST = 6'd47;
   localparam logic [5:0] CRC_SKIP = 6'd4;
   localparam logic [31:0] HDR_BYTES = 32'd48;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

   localparam logic [3:0] FLD_CRC = 4'd0;
   localparam logic [3:0] FLD_TOTAL = 4'd1;
   localparam logic [3:0] FLD_TOPIC_LEN = 4'd5;
   localparam logic [3:0] FLD_KEY_LEN = 4'd6;
   localparam logic [3:0] FLD_VALUE_LEN = 4'd7;

   localparam logic [1:0] KIND_FIELD = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_VERDICT = 2'd2;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_LENGTH = 2'd1;
   localparam logic [1:0] STATUS_CRC = 2'd2;

   typedef struct packed {
      logic [7:0] wire_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  field_id;
      logic [63:0] field_value;
      logic [7:0]  payload_byte;
      logic [1:0]  section;
      logic [1:0]  status;
      logic        last_of_input;
   } rsp_type;

   typedef struct packed {
      rsp_type    first;
      logic       verdict_valid;
      logic [1:0] verdict_status;
   } entry_type;

   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic field_end(input logic [5:0] pos);
      logic hit;
      unique case (pos) inside
         6'd3, 6'd7, 6'd15, 6'd17, 6'd19, 6'd23, 6'd27, 6'd31, 6'd35, 6'd43, 6'd47: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage
`default_nettype wire

// ===== sv/frc_front.sv =====
`default_nettype none
module frc_front
   import frc_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   output logic           req_ready,
   input  wire req_type   req_data,
   output logic           push_valid,
   input  wire logic      push_ready,
   output entry_type      push_entry
);

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_TOPIC = 3'd1;
   localparam logic [2:0] PH_KEY = 3'd2;
   localparam logic [2:0] PH_VALUE = 3'd3;
   localparam logic [2:0] PH_HALT = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] sum_ff, sum_in;
   logic [3:0]  fidx_ff, fidx_in;
   logic [31:0] rcv_crc_ff, rcv_crc_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] topic_ff, topic_in;
   logic [31:0] key_ff, key_in;
   logic [31:0] value_ff, value_in;
   logic [31:0] left_ff, left_in;

   logic        accept;
   logic [2:0]  e_phase;
   logic [5:0]  e_cnt;
   logic [63:0] e_acc;
   logic [31:0] e_crc;
   logic [31:0] e_sum;
   logic [3:0]  e_fidx;
   logic [31:0] crc_next;
   logic [63:0] acc_shift;
   logic        done;
   logic        has_result;
   logic        crc_good;

   assign req_ready = push_ready;
   assign accept = req_valid && req_ready;

   always_comb begin
      e_phase = req_data.frame_start ? PH_HEADER : phase_ff;
      e_cnt = req_data.frame_start ? 6'd0 : cnt_ff;
      e_acc = req_data.frame_start ? 64'd0 : acc_ff;
      e_crc = req_data.frame_start ? CRC_INIT : crc_ff;
      e_sum = req_data.frame_start ? HDR_BYTES : sum_ff;
      e_fidx = req_data.frame_start ? 4'd0 : fidx_ff;
      crc_next = crc32_byte(e_crc, req_data.wire_byte);
      acc_shift = {e_acc[55:0], req_data.wire_byte};
      done = field_end(e_cnt);
      crc_good = (~crc_next == rcv_crc_ff);

      phase_in = e_phase;
      cnt_in = e_cnt;
      acc_in = e_acc;
      crc_in = e_crc;
      sum_in = e_sum;
      fidx_in = e_fidx;
      rcv_crc_in = rcv_crc_ff;
      total_in = total_ff;
      topic_in = topic_ff;
      key_in = key_ff;
      value_in = value_ff;
      left_in = left_ff;
      has_result = 1'b0;
      push_entry = '0;

      unique case (e_phase)
         PH_HEADER: begin
            if (e_cnt >= CRC_SKIP) begin
               crc_in = crc_next;
            end
            acc_in = acc_shift;
            if (done) begin
               has_result = 1'b1;
               push_entry.first.kind = KIND_FIELD;
               push_entry.first.field_id = e_fidx;
               push_entry.first.field_value = acc_shift;
               acc_in = 64'd0;
               fidx_in = e_fidx + 4'd1;
               case (e_fidx)
                  FLD_CRC: rcv_crc_in = acc_shift[31:0];
                  FLD_TOTAL: total_in = acc_shift[31:0];
                  FLD_TOPIC_LEN: begin
                     topic_in = acc_shift[31:0];
                     sum_in = e_sum + acc_shift[31:0];
                  end
                  FLD_KEY_LEN: begin
                     key_in = acc_shift[31:0];
                     sum_in = e_sum + acc_shift[31:0];
                  end
                  FLD_VALUE_LEN: begin
                     value_in = acc_shift[31:0];
                     sum_in = e_sum + acc_shift[31:0];
                  end
                  default: ;
               endcase
            end
            if (e_cnt == HDR_LAST) begin
               cnt_in = 6'd0;
               if (e_sum != total_ff) begin
                  push_entry.verdict_valid = 1'b1;
                  push_entry.verdict_status = STATUS_LENGTH;
                  phase_in = PH_HALT;
               end else if (topic_ff != 32'd0) begin
                  phase_in = PH_TOPIC;
                  left_in = topic_ff;
               end else if (key_ff != 32'd0) begin
                  phase_in = PH_KEY;
                  left_in = key_ff;
               end else if (value_ff != 32'd0) begin
                  phase_in = PH_VALUE;
                  left_in = value_ff;
               end else begin
                  push_entry.verdict_valid = 1'b1;
                  push_entry.verdict_status = crc_good ? STATUS_OK : STATUS_CRC;
                  phase_in = crc_good ? PH_HEADER : PH_HALT;
                  crc_in = CRC_INIT;
                  acc_in = 64'd0;
                  fidx_in = 4'd0;
                  sum_in = HDR_BYTES;
               end
            end else begin
               cnt_in = e_cnt + 6'd1;
            end
         end
         PH_TOPIC, PH_KEY, PH_VALUE: begin
            has_result = 1'b1;
            crc_in = crc_next;
            push_entry.first.kind = KIND_PAYLOAD;
            push_entry.first.payload_byte = req_data.wire_byte;
            push_entry.first.section = 2'(e_phase - PH_TOPIC);
            left_in = left_ff - 32'd1;
            if (left_ff == 32'd1) begin
               if (e_phase == PH_TOPIC && key_ff != 32'd0) begin
                  phase_in = PH_KEY;
                  left_in = key_ff;
               end else if (e_phase != PH_VALUE && value_ff != 32'd0) begin
                  phase_in = PH_VALUE;
                  left_in = value_ff;
               end else begin
                  push_entry.verdict_valid = 1'b1;
                  push_entry.verdict_status = crc_good ? STATUS_OK : STATUS_CRC;
                  phase_in = crc_good ? PH_HEADER : PH_HALT;
                  cnt_in = 6'd0;
                  crc_in = CRC_INIT;
                  acc_in = 64'd0;
                  fidx_in = 4'd0;
                  sum_in = HDR_BYTES;
               end
            end
         end
         default: ;
      endcase

      push_valid = accept && has_result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         cnt_ff <= 6'd0;
         acc_ff <= 64'd0;
         crc_ff <= CRC_INIT;
         sum_ff <= HDR_BYTES;
         fidx_ff <= 4'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         cnt_ff <= cnt_in;
         acc_ff <= acc_in;
         crc_ff <= crc_in;
         sum_ff <= sum_in;
         fidx_ff <= fidx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rcv_crc_ff <= rcv_crc_in;
         total_ff <= total_in;
         topic_ff <= topic_in;
         key_ff <= key_in;
         value_ff <= value_in;
         left_ff <= left_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/frc_queue.sv =====
`default_nettype none
module frc_queue
   import frc_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   output logic           push_ready,
   input  wire entry_type push_entry,
   output logic           pop_valid,
   input  wire logic      pop_ready,
   output entry_type      pop_entry
);

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;
   logic               push, pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ===== sv/frc_back.sv =====
`default_nettype none
module frc_back
   import frc_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      pop_valid,
   output logic           pop_ready,
   input  wire entry_type pop_entry,
   output logic           rsp_valid,
   input  wire logic      rsp_ready,
   output rsp_type        rsp_data
);

   logic       rsp_valid_ff;
   rsp_type    rsp_ff, rsp_in;
   logic       pend_ff;
   logic [1:0] pend_status_ff;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop_ready = out_free && !pend_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      rsp_in = '0;
      if (pend_ff) begin
         rsp_in.kind = KIND_VERDICT;
         rsp_in.status = pend_status_ff;
         rsp_in.last_of_input = 1'b1;
      end else begin
         rsp_in = pop_entry.first;
         rsp_in.last_of_input = !pop_entry.verdict_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else if (out_free) begin
         if (pend_ff) begin
            rsp_valid_ff <= 1'b1;
            pend_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= pop_valid;
            pend_ff <= pop_valid && pop_entry.verdict_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && (pend_ff || pop_valid)) begin
         rsp_ff <= rsp_in;
      end
      if (pop_valid && pop_ready) begin
         pend_status_ff <= pop_entry.verdict_status;
      end
   end

endmodule
`default_nettype wire

// ===== sv/frame_receive_crc_check.sv =====
`default_nettype none
// Receives a byte stream of length-prefixed frames, one byte per transaction, at a sustained
// rate of one byte per clock while the queue has room. The front end parses the 48-byte header,
// tracks payload sections and updates a byte-wide CRC-32 byte by byte; each byte yields zero,
// one or two responses that pass through a four-entry queue to a registered output stage. A
// byte that yields both a response and a frame verdict takes two output slots, so sustained
// one-byte-per-cycle input holds as long as the queue absorbs those extra verdicts. An
// accepted byte's first response is written into the queue, then into the output register.
// After a length or CRC error, bytes are dropped until a transaction with frame_start set.
module frame_receive_crc_check
   import frc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      pop_valid, pop_ready;
   entry_type pop_entry;

   frc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   frc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   frc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
